// File: rtl/core/cga_pkg.sv
package cga_pkg;

	// Store geometry
	localparam int HORIZON_MAX = 64;
	localparam int ADDR_W      = (HORIZON_MAX > 1) ? $clog2(HORIZON_MAX) : 1;
	localparam int CNT_W       = $clog2(HORIZON_MAX + 1);
	localparam int IDX_W       = 6;

	// Fixed point
	localparam int FRAC_W = 16;
	localparam int DISC_W = 17;
	localparam int RAT_W  = 24;
	localparam int VAL_W  = 32;

	// APB register map
	localparam int CFG_AW = 4;
	localparam logic [1:0] REG_DISCOUNT    = 2'd0;
	localparam logic [1:0] REG_TRACE_DECAY = 2'd1;
	localparam logic [1:0] REG_RHO_LIMIT   = 2'd2;
	localparam logic [1:0] REG_TRACE_LIMIT = 2'd3;

	localparam logic [DISC_W-1:0] DISCOUNT_RST    = 17'd65536;
	localparam logic [DISC_W-1:0] TRACE_DECAY_RST = 17'd62259;
	localparam logic [RAT_W-1:0]  RHO_LIMIT_RST   = 24'd65536;
	localparam logic [RAT_W-1:0]  TRACE_LIMIT_RST = 24'd65536;

	localparam logic signed [VAL_W-1:0] ADV_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] ADV_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [VAL_W-1:0] state_value;
		logic signed [VAL_W-1:0] step_reward;
		logic                    episode_done;
		logic [RAT_W-1:0]        importance_ratio;
		logic                    row_end;
	} item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] advantage;
		logic [IDX_W-1:0]        step_index;
		logic                    truncated;
		logic                    last_of_row;
	} result_t;

	typedef struct packed {
		logic [IDX_W-1:0] step_index;
		logic             truncated;
		logic             last_of_row;
	} res_tag_t;

	typedef struct packed {
		logic [DISC_W-1:0] discount;
		logic [DISC_W-1:0] trace_decay;
		logic [RAT_W-1:0]  rho_limit;
		logic [RAT_W-1:0]  trace_limit;
	} cfg_t;

	// One stored timestep
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] reward;
		logic                    done;
		logic [RAT_W-1:0]        ratio;
	} entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic              wr;
		logic              rd;
		logic [ADDR_W-1:0] addr;
		logic              gl_mul;
		logic              gl_rnd;
		logic              clip;
		logic              mul;
		logic              rnd;
		logic              mul2;
		logic              trc;
	} cmd_t;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_GL1  = 9'b000000010,
		S_GL2  = 9'b000000100,
		S_RD   = 9'b000001000,
		S_CLIP = 9'b000010000,
		S_MUL  = 9'b000100000,
		S_RND  = 9'b001000000,
		S_MUL2 = 9'b010000000,
		S_TRC  = 9'b100000000
	} state_t;

endpackage

// File: rtl/core/cga_regs.sv
module cga_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [cga_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output cga_pkg::cfg_t             cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.discount    <= cga_pkg::DISCOUNT_RST;
			cfg.trace_decay <= cga_pkg::TRACE_DECAY_RST;
			cfg.rho_limit   <= cga_pkg::RHO_LIMIT_RST;
			cfg.trace_limit <= cga_pkg::TRACE_LIMIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				cga_pkg::REG_DISCOUNT:    cfg.discount    <= pwdata[cga_pkg::DISC_W-1:0];
				cga_pkg::REG_TRACE_DECAY: cfg.trace_decay <= pwdata[cga_pkg::DISC_W-1:0];
				cga_pkg::REG_RHO_LIMIT:   cfg.rho_limit   <= pwdata[cga_pkg::RAT_W-1:0];
				cga_pkg::REG_TRACE_LIMIT: cfg.trace_limit <= pwdata[cga_pkg::RAT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			cga_pkg::REG_DISCOUNT:    prdata = 32'(cfg.discount);
			cga_pkg::REG_TRACE_DECAY: prdata = 32'(cfg.trace_decay);
			cga_pkg::REG_RHO_LIMIT:   prdata = 32'(cfg.rho_limit);
			cga_pkg::REG_TRACE_LIMIT: prdata = 32'(cfg.trace_limit);
			default:                  prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/cga_ctrl.sv
module cga_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               row_end,
	output logic               busy,
	output cga_pkg::cmd_t      cmd,
	output logic               res_valid,
	output cga_pkg::res_tag_t  res_tag
);

	cga_pkg::state_t                 state_q;
	logic [cga_pkg::CNT_W-1:0]       cnt_q;
	logic                            ovf_q;
	logic [cga_pkg::ADDR_W-1:0]      t_q;
	logic                            valid_q;
	cga_pkg::res_tag_t               tag_q;

	logic                            accept;
	logic                            full;
	logic [cga_pkg::ADDR_W-1:0]      last_addr;

	assign busy      = (state_q != cga_pkg::S_IDLE);
	assign accept    = start & ~busy;
	assign full      = (cnt_q == cga_pkg::CNT_W'(cga_pkg::HORIZON_MAX));
	// index of the last stored step once this transaction is stored
	assign last_addr = full ? cga_pkg::ADDR_W'(cga_pkg::HORIZON_MAX - 1)
	                        : cnt_q[cga_pkg::ADDR_W-1:0];

	assign res_valid = valid_q;
	assign res_tag   = tag_q;

	// Command decode
	always_comb begin
		cmd      = '0;
		cmd.addr = t_q;
		case (state_q)
			cga_pkg::S_IDLE: begin
				cmd.wr   = accept & ~full;
				cmd.addr = cnt_q[cga_pkg::ADDR_W-1:0];
			end
			cga_pkg::S_GL1: begin
				cmd.rd     = 1'b1;
				cmd.gl_mul = 1'b1;
			end
			cga_pkg::S_GL2:  cmd.gl_rnd = 1'b1;
			cga_pkg::S_RD:   cmd.rd     = 1'b1;
			cga_pkg::S_CLIP: cmd.clip   = 1'b1;
			cga_pkg::S_MUL:  cmd.mul    = 1'b1;
			cga_pkg::S_RND:  cmd.rnd    = 1'b1;
			cga_pkg::S_MUL2: cmd.mul2   = 1'b1;
			cga_pkg::S_TRC:  cmd.trc    = 1'b1;
			default: ;
		endcase
	end

	// Sequencer: load steps, then walk the row backward
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cga_pkg::S_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			t_q     <= '0;
			valid_q <= 1'b0;
			tag_q   <= '0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				cga_pkg::S_IDLE: begin
					if (accept) begin
						if (row_end) begin
							cnt_q <= '0;
							t_q   <= last_addr;
							if (!full && cnt_q == '0) begin
								// single-step row: nothing to emit
								ovf_q <= 1'b0;
							end else begin
								ovf_q   <= ovf_q | full;
								state_q <= cga_pkg::S_GL1;
							end
						end else if (full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				cga_pkg::S_GL1: begin
					t_q     <= t_q - 1'b1;
					state_q <= cga_pkg::S_GL2;
				end
				cga_pkg::S_GL2:  state_q <= cga_pkg::S_RD;
				cga_pkg::S_RD:   state_q <= cga_pkg::S_CLIP;
				cga_pkg::S_CLIP: state_q <= cga_pkg::S_MUL;
				cga_pkg::S_MUL:  state_q <= cga_pkg::S_RND;
				cga_pkg::S_RND:  state_q <= cga_pkg::S_MUL2;
				cga_pkg::S_MUL2: state_q <= cga_pkg::S_TRC;
				cga_pkg::S_TRC: begin
					valid_q           <= 1'b1;
					tag_q.step_index  <= cga_pkg::IDX_W'(t_q);
					tag_q.truncated   <= ovf_q;
					tag_q.last_of_row <= (t_q == '0);
					if (t_q == '0) begin
						ovf_q   <= 1'b0;
						state_q <= cga_pkg::S_IDLE;
					end else begin
						t_q     <= t_q - 1'b1;
						state_q <= cga_pkg::S_RD;
					end
				end
				default: state_q <= cga_pkg::S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/cga_dp.sv
module cga_dp (
	input  logic                              clk,
	input  cga_pkg::cmd_t                     cmd,
	input  cga_pkg::item_t                    item,
	input  cga_pkg::cfg_t                     cfg,
	output logic signed [cga_pkg::VAL_W-1:0]  advantage
);

	// Row store, one entry per timestep
	cga_pkg::entry_t mem [cga_pkg::HORIZON_MAX];
	cga_pkg::entry_t wr_entry;
	cga_pkg::entry_t rd_q;   // step t
	cga_pkg::entry_t nxt_q;  // step t+1

	logic [33:0]        glp_q;
	logic [17:0]        gl_q;
	logic [23:0]        rho_q;
	logic [23:0]        c_q;
	logic signed [56:0] p1_q;
	logic signed [49:0] p2_q;
	logic [41:0]        p3_q;
	logic signed [40:0] term1_q;
	logic signed [33:0] term2_q;
	logic [25:0]        glc_q;
	logic signed [58:0] p4_q;
	logic signed [42:0] delta_q;
	logic signed [31:0] adv_q;

	logic [34:0]        gl_sum;
	logic [23:0]        rho;
	logic [23:0]        c;
	logic signed [56:0] p1;
	logic signed [49:0] p2;
	logic [41:0]        p3;
	logic signed [56:0] r1;
	logic signed [49:0] r2;
	logic [41:0]        r3;
	logic signed [58:0] p4;
	logic signed [58:0] r4;
	logic signed [42:0] trace;
	logic signed [43:0] adv_sum;
	logic signed [31:0] adv_sat;
	logic               live;

	assign wr_entry.value  = item.state_value;
	assign wr_entry.reward = item.step_reward;
	assign wr_entry.done   = item.episode_done;
	assign wr_entry.ratio  = item.importance_ratio;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[cmd.addr] <= wr_entry;
		end
		if (cmd.rd) begin
			rd_q <= mem[cmd.addr];
		end
	end

	assign live = ~nxt_q.done;

	// gamma*lambda, rounded to Q.16
	assign gl_sum = {1'b0, glp_q} + 35'd32768;

	// Ratio clipping
	assign rho = (rd_q.ratio < cfg.rho_limit)   ? rd_q.ratio : cfg.rho_limit;
	assign c   = (rd_q.ratio < cfg.trace_limit) ? rd_q.ratio : cfg.trace_limit;

	// Products, each registered
	assign p1 = 57'($signed({1'b0, rho_q})) * 57'(nxt_q.reward);
	assign p2 = 50'($signed({1'b0, cfg.discount})) * 50'(nxt_q.value);
	assign p3 = 42'(gl_q) * 42'(c_q);
	assign p4 = 59'($signed({1'b0, glc_q})) * 59'(adv_q);

	// Round half up back to 16 fraction bits
	assign r1    = p1_q + 57'sd32768;
	assign r2    = p2_q + 50'sd32768;
	assign r3    = p3_q + 42'd32768;
	assign r4    = p4_q + 59'sd32768;
	assign trace = live ? r4[58:16] : '0;

	// Final sum and saturation
	assign adv_sum = 44'(delta_q) + 44'(trace);
	always_comb begin
		if (adv_sum > 44'(cga_pkg::ADV_MAX)) begin
			adv_sat = cga_pkg::ADV_MAX;
		end else if (adv_sum < 44'(cga_pkg::ADV_MIN)) begin
			adv_sat = cga_pkg::ADV_MIN;
		end else begin
			adv_sat = adv_sum[31:0];
		end
	end

	// Step datapath
	always_ff @(posedge clk) begin
		if (cmd.gl_mul) begin
			glp_q <= 34'(cfg.discount) * 34'(cfg.trace_decay);
		end
		if (cmd.gl_rnd) begin
			gl_q  <= gl_sum[33:16];
			nxt_q <= rd_q;
			adv_q <= '0;
		end
		if (cmd.clip) begin
			rho_q <= rho;
			c_q   <= c;
		end
		if (cmd.mul) begin
			p1_q <= p1;
			p2_q <= p2;
			p3_q <= p3;
		end
		if (cmd.rnd) begin
			term1_q <= r1[56:16];
			term2_q <= live ? r2[49:16] : '0;
			glc_q   <= r3[41:16];
		end
		if (cmd.mul2) begin
			p4_q    <= p4;
			delta_q <= 43'(term1_q) + 43'(term2_q) - 43'(rd_q.value);
		end
		if (cmd.trc) begin
			adv_q <= adv_sat;
			nxt_q <= rd_q;
		end
	end

	assign advantage = adv_q;

endmodule

// File: rtl/core/clipped_gae_advantage.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------
// input     | start, busy          | item   (cga_pkg::item_t)
// result    | result_valid strobe  | result (cga_pkg::result_t)
// config    | APB psel/penable     | paddr, pwdata, prdata, pready
//
// Loading accepts one timestep per cycle; busy stays low until row_end arrives.
// On row end: setup states GL1 and GL2, then per advantage the steps store read, clip,
// three parallel multiplies, rounding, trace multiply, sum and saturate.
// The trace multiply depends on the previous advantage, so advantages are not overlapped.
// A row of L stored steps yields L-1 advantages, all within one busy period.
// Reset clears the sequencer, counters and config registers; the row store is not cleared.
// Each result is strobed for one cycle and cannot be stalled by the receiver.
module clipped_gae_advantage (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  cga_pkg::item_t             item,
	output logic                       result_valid,
	output cga_pkg::result_t           result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cga_pkg::CFG_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	cga_pkg::cfg_t                   cfg;
	cga_pkg::cmd_t                   cmd;
	cga_pkg::res_tag_t               res_tag;
	logic signed [cga_pkg::VAL_W-1:0] advantage;

	cga_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cga_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.row_end   (item.row_end),
		.busy      (busy),
		.cmd       (cmd),
		.res_valid (result_valid),
		.res_tag   (res_tag)
	);

	cga_dp u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.item      (item),
		.cfg       (cfg),
		.advantage (advantage)
	);

	assign result.advantage   = advantage;
	assign result.step_index  = res_tag.step_index;
	assign result.truncated   = res_tag.truncated;
	assign result.last_of_row = res_tag.last_of_row;

	// a result only follows a cycle of backward-pass work
	a_res_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobed without a preceding busy cycle");

	// the block is free again exactly when the final result of a row shows
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (busy == !result.last_of_row))
		else $error("busy does not match last_of_row on a result");

	// results of one row are spaced by the step sequence
	a_res_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_of_row |=> !result_valid)
		else $error("back-to-back results within a row");

endmodule
